// ===== rtl/lbfv_pkg.sv =====
// Lorentz boost core: shared item types, pipeline context, status codes and a rounding helper.
// No dependencies; every module of the core imports this package.
package lbfv_pkg;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_SAT     = 2'd2;

	localparam logic [63:0] ONE60 = 64'h1000_0000_0000_0000;

	typedef struct packed {
		logic signed [31:0] particle_px;
		logic signed [31:0] particle_py;
		logic signed [31:0] particle_pz;
		logic [30:0]        particle_energy;
		logic signed [31:0] parent_px;
		logic signed [31:0] parent_py;
		logic signed [31:0] parent_pz;
		logic [30:0]        parent_energy;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] boosted_px;
		logic signed [31:0] boosted_py;
		logic signed [31:0] boosted_pz;
		logic [30:0]        boosted_energy;
		logic [1:0]         status;
	} out_item_t;

	// particle fields and parent flags ahead of the beta division
	typedef struct packed {
		logic [2:0][31:0] p;
		logic [30:0]      e;
		logic [2:0]       neg;
		logic             inv;
	} front_t;

	// context carried from beta onwards; later fields fill in as they become known
	typedef struct packed {
		logic [2:0][31:0] p;
		logic [30:0]      e;
		logic [2:0]       neg;
		logic             inv;
		logic [2:0][30:0] bm;
		logic [50:0]      dot;
		logic [31:0]      g;
		logic             sat;
		logic [63:0]      e16;
	} ctx_t;

	// round(x / 2^sh), ties away from zero, on a two's complement word
	function automatic logic [65:0] rnd_shr(input logic [65:0] x, input int unsigned sh);
		logic [65:0] m;
		logic [65:0] r;
		m = x[65] ? (~x + 66'd1) : x;
		r = (m + (66'd1 << (sh - 1))) >> sh;
		return x[65] ? (~r + 66'd1) : r;
	endfunction

endpackage

// ===== rtl/lbfv_chan_if.sv =====
// Lorentz boost core: valid/ready channel carrying one item of type T.
// Depends on nothing; the payload type is given per instance.
interface lbfv_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/lorentz_boost_four_vector_core.sv =====
// Lorentz boost core top level: boosts one particle four-momentum by its parent.
// Throughput one item per cycle while the output is not stalled.
// Depth set by the beta, gamma and gamma/(1+gamma) dividers and the square root,
// one result bit per stage each. A stall at the output holds every stage.
// arst_n clears all valid bits at once; no clearing pass, ready after release.
// Depends on lbfv_pkg, lbfv_chan_if, lbfv_div_pipe, lbfv_sqrt_pipe, lbfv_mul_shr.
module lorentz_boost_four_vector_core
	import lbfv_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	lbfv_chan_if.sink   feed,
	lbfv_chan_if.source boost
);

	logic en;
	in_item_t d;
	assign d = feed.data;

	// s1: magnitudes and parent checks
	logic v_s1, v_s2, v_s3;
	logic [2:0][31:0] p_s1, m_s1, p_s2, m_s2, p_s3, m_s3;
	logic [30:0] e_s1, ep_s1, e_s2, ep_s2, e_s3, ep_s3;
	logic [2:0] neg_s1, neg_s2, neg_s3;
	logic inv_s1, inv_s2, inv_s3;
	logic [2:0][61:0] sq_s2;
	logic [61:0] epsq_s2;

	logic [2:0][31:0] p_in, pp_in, m_in;
	logic inv_in;
	assign p_in  = {d.particle_pz, d.particle_py, d.particle_px};
	assign pp_in = {d.parent_pz, d.parent_py, d.parent_px};
	always_comb begin
		inv_in = (d.parent_energy == 31'd0);
		for (int i = 0; i < 3; i++) begin
			m_in[i] = pp_in[i][31] ? (~pp_in[i] + 32'd1) : pp_in[i];
			inv_in  = inv_in | (m_in[i] >= {1'b0, d.parent_energy});
		end
	end

	logic [63:0] psq;
	assign psq = 64'(sq_s2[0]) + 64'(sq_s2[1]) + 64'(sq_s2[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= feed.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1    <= p_in;
			m_s1    <= m_in;
			e_s1    <= d.particle_energy;
			ep_s1   <= d.parent_energy;
			inv_s1  <= inv_in;
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= pp_in[i][31];
				sq_s2[i]  <= 62'(m_s1[i][30:0] * m_s1[i][30:0]);
			end
			epsq_s2 <= 62'(ep_s1 * ep_s1);
			p_s2    <= p_s1;
			m_s2    <= m_s1;
			e_s2    <= e_s1;
			ep_s2   <= ep_s1;
			neg_s2  <= neg_s1;
			inv_s2  <= inv_s1;
			p_s3    <= p_s2;
			m_s3    <= m_s2;
			e_s3    <= e_s2;
			ep_s3   <= ep_s2;
			neg_s3  <= neg_s2;
			inv_s3  <= inv_s2 | (psq >= {2'd0, epsq_s2});
		end
	end

	// beta = round(|P| * 2^30 / E_parent)
	logic [2:0][30:0] b_rem, b_num, b_den, b_quo;
	front_t front_in, front_out;
	logic v_b;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			b_rem[i] = {1'b0, m_s3[i][30:1]};
			b_num[i] = {m_s3[i][0], ep_s3[30:1]};
			b_den[i] = ep_s3;
		end
	end
	assign front_in = '{p: p_s3, e: e_s3, neg: neg_s3, inv: inv_s3};

	lbfv_div_pipe #(.LANES(3), .DW(31), .QW(31), .SIDE_T(front_t)) u_beta_div (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(v_s3),
		.rem_in(b_rem), .num_in(b_num), .den_in(b_den), .side_in(front_in),
		.vld_out(v_b), .quo_out(b_quo), .side_out(front_out)
	);

	// s4..s6: beta squared, dot product, 1 - beta^2
	logic v_s4, v_s5, v_s6;
	ctx_t ctx_s4, ctx_s5, ctx_s6, ctx_b;
	ctx_t ctx_s5_nx, ctx_s6_nx;
	logic [2:0][61:0] bsq_s4;
	logic [2:0][63:0] bp_s4, bp_nx;
	logic [2:0][31:0] bs;
	logic [63:0] beta2;
	logic [65:0] dsum_s5;
	logic [65:0] dot_full;
	logic [60:0] d_s5, d_s6;

	always_comb begin
		ctx_b     = '0;
		ctx_b.p   = front_out.p;
		ctx_b.e   = front_out.e;
		ctx_b.neg = front_out.neg;
		ctx_b.inv = front_out.inv;
		ctx_b.bm  = b_quo;
		for (int i = 0; i < 3; i++) begin
			bs[i]    = front_out.neg[i] ? (~{1'b0, b_quo[i]} + 32'd1) : {1'b0, b_quo[i]};
			bp_nx[i] = 64'($signed(bs[i]) * $signed(front_out.p[i]));
		end
	end
	assign beta2 = 64'(bsq_s4[0]) + 64'(bsq_s4[1]) + 64'(bsq_s4[2]);
	assign dot_full = rnd_shr(dsum_s5, 14);

	always_comb begin
		ctx_s5_nx     = ctx_s4;
		ctx_s5_nx.inv = ctx_s4.inv | (beta2 >= ONE60);
		ctx_s6_nx     = ctx_s5;
		ctx_s6_nx.dot = dot_full[50:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_b;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s4 <= ctx_b;
			for (int i = 0; i < 3; i++) begin
				bsq_s4[i] <= 62'(b_quo[i] * b_quo[i]);
			end
			bp_s4      <= bp_nx;
			ctx_s5     <= ctx_s5_nx;
			d_s5       <= 61'(ONE60 - beta2);
			dsum_s5    <= {{2{bp_s4[0][63]}}, bp_s4[0]} + {{2{bp_s4[1][63]}}, bp_s4[1]}
				+ {{2{bp_s4[2][63]}}, bp_s4[2]};
			ctx_s6     <= ctx_s6_nx;
			d_s6       <= d_s5;
		end
	end

	// s = floor(sqrt(1 - beta^2)) in Q.30
	logic v_q;
	logic [30:0] root;
	ctx_t ctx_q;
	lbfv_sqrt_pipe #(.SW(31), .SIDE_T(ctx_t)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(v_s6),
		.v_in({1'b0, d_s6}), .side_in(ctx_s6),
		.vld_out(v_q), .root_out(root), .side_out(ctx_q)
	);

	// s7: gamma = round(2^46 / s); saturate when s is at most 2^14
	logic v_s7;
	ctx_t ctx_s7, ctx_s7_nx;
	logic [30:0] s_s7;
	always_comb begin
		ctx_s7_nx     = ctx_q;
		ctx_s7_nx.sat = (root <= 31'd16384);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_q;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s7     <= ctx_s7_nx;
			s_s7       <= root;
		end
	end

	logic v_g;
	logic [31:0] g_quo;
	ctx_t ctx_g;
	lbfv_div_pipe #(.LANES(1), .DW(31), .QW(32), .SIDE_T(ctx_t)) u_gamma_div (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(v_s7),
		.rem_in(31'd16384), .num_in({2'b00, s_s7[30:1]}), .den_in(s_s7),
		.side_in(ctx_s7),
		.vld_out(v_g), .quo_out(g_quo), .side_out(ctx_g)
	);

	// s8: ratio operands for gamma / (1 + gamma)
	logic v_s8;
	ctx_t ctx_s8, ctx_s8_nx;
	logic [31:0] g_nx;
	logic [32:0] rden_nx, rden_s8;
	logic [62:0] rnum_s8;
	assign g_nx    = ctx_g.sat ? 32'hFFFF_FFFF : g_quo;
	assign rden_nx = 33'd65536 + {1'b0, g_nx};
	always_comb begin
		ctx_s8_nx   = ctx_g;
		ctx_s8_nx.g = g_nx;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_g;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s8   <= ctx_s8_nx;
			rden_s8  <= rden_nx;
			rnum_s8  <= {1'b0, g_nx, 30'd0} + {31'd0, rden_nx[32:1]};
		end
	end

	logic v_r;
	logic [30:0] r30;
	ctx_t ctx_r;
	lbfv_div_pipe #(.LANES(1), .DW(33), .QW(31), .SIDE_T(ctx_t)) u_ratio_div (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(v_s8),
		.rem_in({1'b0, rnum_s8[62:31]}), .num_in(rnum_s8[30:0]), .den_in(rden_s8),
		.side_in(ctx_s8),
		.vld_out(v_r), .quo_out(r30), .side_out(ctx_r)
	);

	// t = dot * gamma / (1 + gamma)
	logic v_t, sat_t;
	logic [63:0] t_res;
	ctx_t ctx_t1;
	lbfv_mul_shr #(.LANES(1), .SH(30), .SIDE_T(ctx_t)) u_mul_t (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(v_r),
		.x_in({{13{ctx_r.dot[50]}}, ctx_r.dot}), .g_in({1'b0, r30}), .side_in(ctx_r),
		.vld_out(v_t), .res_out(t_res), .sat_out(sat_t), .side_out(ctx_t1)
	);

	// s9: operands of the two gamma products
	logic v_s9;
	ctx_t ctx_s9, ctx_s9_nx;
	logic [63:0] x1_s9, x2_s9, e_sh;
	assign e_sh = {17'd0, ctx_t1.e, 16'd0};
	always_comb begin
		ctx_s9_nx     = ctx_t1;
		ctx_s9_nx.sat = ctx_t1.sat | sat_t;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= v_t;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s9     <= ctx_s9_nx;
			x1_s9      <= t_res + e_sh;
			x2_s9      <= e_sh + {{13{ctx_t1.dot[50]}}, ctx_t1.dot};
		end
	end

	logic v_pg, sat_g;
	logic [1:0][63:0] pg_res;
	ctx_t ctx_pg, ctx_pb;
	lbfv_mul_shr #(.LANES(2), .SH(16), .SIDE_T(ctx_t)) u_mul_g (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(v_s9),
		.x_in({x2_s9, x1_s9}), .g_in({ctx_s9.g, ctx_s9.g}), .side_in(ctx_s9),
		.vld_out(v_pg), .res_out(pg_res), .sat_out(sat_g), .side_out(ctx_pg)
	);

	always_comb begin
		ctx_pb     = ctx_pg;
		ctx_pb.sat = ctx_pg.sat | sat_g;
		ctx_pb.e16 = pg_res[1];
	end

	// beta_i * prod
	logic v_tb, sat_b;
	logic [2:0][63:0] term;
	ctx_t ctx_tb;
	lbfv_mul_shr #(.LANES(3), .SH(30), .SIDE_T(ctx_t)) u_mul_b (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(v_pg),
		.x_in({pg_res[0], pg_res[0], pg_res[0]}),
		.g_in({{1'b0, ctx_pg.bm[2]}, {1'b0, ctx_pg.bm[1]}, {1'b0, ctx_pg.bm[0]}}),
		.side_in(ctx_pb),
		.vld_out(v_tb), .res_out(term), .sat_out(sat_b), .side_out(ctx_tb)
	);

	// s10: boosted momentum in Q.16
	logic v_s10;
	ctx_t ctx_s10, ctx_s10_nx;
	logic [2:0][64:0] qsum_s10, qsum_nx;
	always_comb begin
		ctx_s10_nx     = ctx_tb;
		ctx_s10_nx.sat = ctx_tb.sat | sat_b;
		for (int i = 0; i < 3; i++) begin
			qsum_nx[i] = {{17{ctx_tb.p[i][31]}}, ctx_tb.p[i], 16'd0}
				+ (ctx_tb.neg[i] ? (~{term[i][63], term[i]} + 65'd1)
				                 : {term[i][63], term[i]});
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s10 <= v_tb;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s10     <= ctx_s10_nx;
			qsum_s10    <= qsum_nx;
		end
	end

	// output register: round, saturate, select pass-through
	logic out_v_q;
	out_item_t out_nx, out_q;
	logic [2:0][65:0] qr;
	logic [2:0][31:0] qo;
	logic [65:0] er;
	logic [30:0] eo;
	logic sat_f;
	always_comb begin
		sat_f = ctx_s10.sat;
		for (int i = 0; i < 3; i++) begin
			qr[i] = rnd_shr({qsum_s10[i][64], qsum_s10[i]}, 16);
			if (!qr[i][65] && (|qr[i][64:31])) begin
				qo[i] = 32'h7FFF_FFFF;
				sat_f = 1'b1;
			end else if (qr[i][65] && !(&qr[i][64:31])) begin
				qo[i] = 32'h8000_0000;
				sat_f = 1'b1;
			end else begin
				qo[i] = qr[i][31:0];
			end
		end
		er = rnd_shr({{2{ctx_s10.e16[63]}}, ctx_s10.e16}, 16);
		if (er[65]) begin
			eo    = 31'd0;
			sat_f = 1'b1;
		end else if (|er[64:31]) begin
			eo    = 31'h7FFF_FFFF;
			sat_f = 1'b1;
		end else begin
			eo = er[30:0];
		end
		if (ctx_s10.inv) begin
			out_nx.boosted_px     = ctx_s10.p[0];
			out_nx.boosted_py     = ctx_s10.p[1];
			out_nx.boosted_pz     = ctx_s10.p[2];
			out_nx.boosted_energy = ctx_s10.e;
			out_nx.status         = ST_INVALID;
		end else begin
			out_nx.boosted_px     = qo[0];
			out_nx.boosted_py     = qo[1];
			out_nx.boosted_pz     = qo[2];
			out_nx.boosted_energy = eo;
			out_nx.status         = sat_f ? ST_SAT : ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= v_s10;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= out_nx;
		end
	end

	assign en          = !out_v_q || boost.ready;
	assign feed.ready  = en;
	assign boost.valid = out_v_q;
	assign boost.data  = out_q;

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(feed.valid && feed.ready) |=> v_s1)
		else $error("accepted item missing from first stage");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(v_s1) && $stable(v_s10) && out_v_q))
		else $error("pipeline moved during output stall");

	a_invalid_status: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s10 && en && ctx_s10.inv) |=> (boost.valid && boost.data.status == ST_INVALID))
		else $error("invalid parent not reported");

endmodule

// ===== rtl/lbfv_div_pipe.sv =====
// Lorentz boost core: restoring divider, one quotient bit per pipeline stage.
// Depends on lbfv_pkg; carries a side item of any type alongside the lanes.
module lbfv_div_pipe
	import lbfv_pkg::*;
#(
	parameter int LANES = 1,
	parameter int DW = 32,
	parameter int QW = 32,
	parameter type SIDE_T = logic
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         vld_in,
	input  logic [LANES-1:0][DW-1:0]     rem_in,
	input  logic [LANES-1:0][QW-1:0]     num_in,
	input  logic [LANES-1:0][DW-1:0]     den_in,
	input  SIDE_T                        side_in,
	output logic                         vld_out,
	output logic [LANES-1:0][QW-1:0]     quo_out,
	output SIDE_T                        side_out
);

	logic                     vld_s  [QW];
	logic [LANES-1:0][DW-1:0] rem_s  [QW];
	logic [LANES-1:0][QW-1:0] nq_s   [QW];
	logic [LANES-1:0][DW-1:0] den_s  [QW];
	SIDE_T                    side_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic                     vld_cur;
		logic [LANES-1:0][DW-1:0] rem_cur, den_cur, rem_nx;
		logic [LANES-1:0][QW-1:0] nq_cur, nq_nx;
		SIDE_T                    side_cur;

		if (k == 0) begin : g_first
			assign vld_cur  = vld_in;
			assign rem_cur  = rem_in;
			assign nq_cur   = num_in;
			assign den_cur  = den_in;
			assign side_cur = side_in;
		end else begin : g_next
			assign vld_cur  = vld_s[k-1];
			assign rem_cur  = rem_s[k-1];
			assign nq_cur   = nq_s[k-1];
			assign den_cur  = den_s[k-1];
			assign side_cur = side_s[k-1];
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [DW:0] trial;
			logic        ge;
			assign trial     = {rem_cur[l], nq_cur[l][QW-1]};
			assign ge        = trial >= {1'b0, den_cur[l]};
			assign rem_nx[l] = ge ? DW'(trial - {1'b0, den_cur[l]}) : trial[DW-1:0];
			assign nq_nx[l]  = {nq_cur[l][QW-2:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_cur;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= rem_nx;
				nq_s[k]   <= nq_nx;
				den_s[k]  <= den_cur;
				side_s[k] <= side_cur;
			end
		end
	end

	assign vld_out  = vld_s[QW-1];
	assign quo_out  = nq_s[QW-1];
	assign side_out = side_s[QW-1];

endmodule

// ===== rtl/lbfv_sqrt_pipe.sv =====
// Lorentz boost core: integer square root, one result bit per pipeline stage.
// Depends on lbfv_pkg; returns floor(sqrt(v)) with a side item carried along.
module lbfv_sqrt_pipe
	import lbfv_pkg::*;
#(
	parameter int SW = 31,
	parameter type SIDE_T = logic
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vld_in,
	input  logic [2*SW-1:0] v_in,
	input  SIDE_T           side_in,
	output logic            vld_out,
	output logic [SW-1:0]   root_out,
	output SIDE_T           side_out
);

	logic            vld_s  [SW];
	logic [2*SW-1:0] v_s    [SW];
	logic [2*SW:0]   r_s    [SW];
	SIDE_T           side_s [SW];

	for (genvar k = 0; k < SW; k++) begin : g_step
		localparam logic [2*SW:0] BIT = (2*SW+1)'(1) << (2 * (SW - 1 - k));
		logic            vld_cur;
		logic [2*SW-1:0] v_cur, v_nx;
		logic [2*SW:0]   r_cur, r_nx, trial;
		logic            ge;
		SIDE_T           side_cur;

		if (k == 0) begin : g_first
			assign vld_cur  = vld_in;
			assign v_cur    = v_in;
			assign r_cur    = '0;
			assign side_cur = side_in;
		end else begin : g_next
			assign vld_cur  = vld_s[k-1];
			assign v_cur    = v_s[k-1];
			assign r_cur    = r_s[k-1];
			assign side_cur = side_s[k-1];
		end

		assign trial = r_cur + BIT;
		assign ge    = {1'b0, v_cur} >= trial;
		assign v_nx  = ge ? (2*SW)'({1'b0, v_cur} - trial) : v_cur;
		assign r_nx  = ge ? ((r_cur >> 1) + BIT) : (r_cur >> 1);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_cur;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				v_s[k]    <= v_nx;
				r_s[k]    <= r_nx;
				side_s[k] <= side_cur;
			end
		end
	end

	assign vld_out  = vld_s[SW-1];
	assign root_out = r_s[SW-1][SW-1:0];
	assign side_out = side_s[SW-1];

endmodule

// ===== rtl/lbfv_mul_shr.sv =====
// Lorentz boost core: round(x * g / 2^SH) with magnitude clamp at 2^62.
// Depends on lbfv_pkg; three stages: magnitude, split products, combine.
module lbfv_mul_shr
	import lbfv_pkg::*;
#(
	parameter int LANES = 1,
	parameter int SH = 16,
	parameter type SIDE_T = logic
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     vld_in,
	input  logic [LANES-1:0][63:0]   x_in,
	input  logic [LANES-1:0][31:0]   g_in,
	input  SIDE_T                    side_in,
	output logic                     vld_out,
	output logic [LANES-1:0][63:0]   res_out,
	output logic                     sat_out,
	output SIDE_T                    side_out
);

	localparam logic [63:0] CAP62 = 64'h4000_0000_0000_0000;

	logic vld_s1, vld_s2, vld_s3;
	SIDE_T side_s1, side_s2, side_s3;
	logic [LANES-1:0][62:0] mc_s1;
	logic [LANES-1:0][31:0] g_s1;
	logic [LANES-1:0]       neg_s1, clp_s1, neg_s2, clp_s2, sat_s3;
	logic [LANES-1:0][63:0] lo_s2;
	logic [LANES-1:0][62:0] hi_s2;
	logic [LANES-1:0][63:0] res_s3;

	logic [LANES-1:0][62:0] mc_nx;
	logic [LANES-1:0]       clp_nx, sat_nx;
	logic [LANES-1:0][63:0] res_nx;

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		logic [63:0] m;
		logic [94:0] prod, wr;
		logic        big, over;
		logic [62:0] rm;

		assign m         = x_in[l][63] ? (~x_in[l] + 64'd1) : x_in[l];
		assign clp_nx[l] = m > CAP62;
		assign mc_nx[l]  = clp_nx[l] ? CAP62[62:0] : m[62:0];

		assign prod = {hi_s2[l], 32'd0} + {31'd0, lo_s2[l]};
		assign big  = hi_s2[l] >= (63'(1) << (30 + SH));
		assign wr   = (prod + (95'(1) << (SH - 1))) >> SH;
		assign over = wr > {31'd0, CAP62};
		assign rm   = over ? CAP62[62:0] : wr[62:0];
		assign sat_nx[l] = clp_s2[l] | big | over;
		assign res_nx[l] = neg_s2[l] ? (~{1'b0, rm} + 64'd1) : {1'b0, rm};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < LANES; l++) begin
				mc_s1[l]  <= mc_nx[l];
				g_s1[l]   <= g_in[l];
				neg_s1[l] <= x_in[l][63];
				clp_s1[l] <= clp_nx[l];
				lo_s2[l]  <= 64'(mc_s1[l][31:0] * g_s1[l]);
				hi_s2[l]  <= 63'(mc_s1[l][62:32] * g_s1[l]);
			end
			neg_s2  <= neg_s1;
			clp_s2  <= clp_s1;
			res_s3  <= res_nx;
			sat_s3  <= sat_nx;
			side_s1 <= side_in;
			side_s2 <= side_s1;
			side_s3 <= side_s2;
		end
	end

	assign vld_out  = vld_s3;
	assign res_out  = res_s3;
	assign sat_out  = |sat_s3;
	assign side_out = side_s3;

endmodule

// ===== tb/lbfv_boost_checker.sv =====
// Lorentz boost core checker: watches the feed and boost channels, works out each boost
// in fixed point and compares every delivered item with the oldest one worked out.
// Depends on lbfv_pkg for the item types and status codes.
`timescale 1ns / 100ps
module lbfv_boost_checker
	import lbfv_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      feed_valid,
	input  logic      feed_ready,
	input  in_item_t  feed_data,
	input  logic      boost_valid,
	input  logic      boost_ready,
	input  out_item_t boost_data,
	output int        mismatches,
	output int        outstanding
);

	localparam longint unsigned CAP62 = 64'd1 << 62;

	out_item_t expected_boosts[$];

	function automatic longint unsigned umag(input longint x);
		return x < 0 ? longint'(-x) : longint'(x);
	endfunction

	function automatic longint round_shift(input longint x, input int sh);
		longint unsigned m;
		longint unsigned r;
		m = umag(x);
		r = (m + (64'd1 << (sh - 1))) >> sh;
		return x < 0 ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint scale_clamped(input longint x, input longint unsigned g,
		input int sh, inout bit sat);
		longint unsigned m;
		longint unsigned hi;
		longint unsigned lo;
		longint unsigned res;
		m = umag(x);
		if (m > CAP62) begin
			m = CAP62;
			sat = 1'b1;
		end
		hi = (m >> 32) * g;
		lo = (m & 64'hFFFF_FFFF) * g;
		if (hi >= (64'd1 << (30 + sh))) begin
			res = CAP62;
			sat = 1'b1;
		end else begin
			res = (hi << (32 - sh)) + (lo >> sh) + ((lo >> (sh - 1)) & 64'd1);
			if (res > CAP62) begin
				res = CAP62;
				sat = 1'b1;
			end
		end
		return x < 0 ? -longint'(res) : longint'(res);
	endfunction

	function automatic longint unsigned floor_sqrt(input longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic out_item_t boost_four_vector(input in_item_t x);
		out_item_t res;
		longint unsigned e;
		longint unsigned ep;
		longint unsigned m;
		longint unsigned psq;
		longint unsigned b2;
		longint unsigned s;
		longint unsigned g;
		longint unsigned r30;
		longint pv[3];
		longint pp[3];
		longint bt[3];
		longint q[3];
		longint dot;
		longint t;
		longint prod;
		longint e16;
		longint eo;
		longint term;
		bit inv;
		bit sat;
		e = x.particle_energy;
		ep = x.parent_energy;
		pv[0] = x.particle_px;
		pv[1] = x.particle_py;
		pv[2] = x.particle_pz;
		pp[0] = x.parent_px;
		pp[1] = x.parent_py;
		pp[2] = x.parent_pz;
		inv = (ep == 0);
		sat = 1'b0;
		psq = 0;
		b2 = 0;
		for (int i = 0; i < 3; i++) begin
			m = umag(pp[i]);
			bt[i] = 0;
			if (m >= ep) begin
				inv = 1'b1;
			end else begin
				psq = psq + m * m;
				m = ((m << 30) + (ep >> 1)) / ep;
				b2 = b2 + m * m;
				bt[i] = pp[i] < 0 ? -longint'(m) : longint'(m);
			end
		end
		if (!inv && (psq >= ep * ep || b2 >= ONE60))
			inv = 1'b1;
		if (inv) begin
			res.boosted_px = x.particle_px;
			res.boosted_py = x.particle_py;
			res.boosted_pz = x.particle_pz;
			res.boosted_energy = x.particle_energy;
			res.status = ST_INVALID;
			return res;
		end
		s = floor_sqrt(ONE60 - b2);
		g = ((64'd1 << 46) + (s >> 1)) / s;
		if (g > 64'hFFFF_FFFF) begin
			g = 64'hFFFF_FFFF;
			sat = 1'b1;
		end
		dot = round_shift(bt[0] * pv[0] + bt[1] * pv[1] + bt[2] * pv[2], 14);
		r30 = ((g << 30) + ((64'd65536 + g) >> 1)) / (64'd65536 + g);
		t = scale_clamped(dot, r30, 30, sat);
		prod = scale_clamped(t + longint'(e << 16), g, 16, sat);
		e16 = scale_clamped(longint'(e << 16) + dot, g, 16, sat);
		for (int i = 0; i < 3; i++) begin
			term = scale_clamped(prod, umag(bt[i]), 30, sat);
			if (bt[i] < 0)
				term = -term;
			q[i] = round_shift(pv[i] * 65536 + term, 16);
			if (q[i] > 64'sd2147483647) begin
				q[i] = 64'sd2147483647;
				sat = 1'b1;
			end
			if (q[i] < -64'sd2147483648) begin
				q[i] = -64'sd2147483648;
				sat = 1'b1;
			end
		end
		eo = round_shift(e16, 16);
		if (eo < 0) begin
			eo = 0;
			sat = 1'b1;
		end
		if (eo > 64'sd2147483647) begin
			eo = 64'sd2147483647;
			sat = 1'b1;
		end
		res.boosted_px = q[0][31:0];
		res.boosted_py = q[1][31:0];
		res.boosted_pz = q[2][31:0];
		res.boosted_energy = eo[30:0];
		res.status = sat ? ST_SAT : ST_OK;
		return res;
	endfunction

	task automatic compare_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	initial mismatches = 0;
	assign outstanding = expected_boosts.size();

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			expected_boosts.delete();
		end else begin
			if (feed_valid && feed_ready)
				expected_boosts = {expected_boosts, boost_four_vector(feed_data)};
			if (boost_valid && boost_ready) begin
				if (expected_boosts.size() == 0) begin
					$display("%0t: boost item with none expected, got %h", $time, boost_data);
					mismatches++;
				end else begin
					want = expected_boosts.pop_front();
					compare_field("boosted_px", want.boosted_px, boost_data.boosted_px);
					compare_field("boosted_py", want.boosted_py, boost_data.boosted_py);
					compare_field("boosted_pz", want.boosted_pz, boost_data.boosted_pz);
					compare_field("boosted_energy", want.boosted_energy,
						boost_data.boosted_energy);
					compare_field("status", want.status, boost_data.status);
				end
			end
		end
	end

endmodule

// ===== tb/tb_lorentz_boost_four_vector_core.sv =====
// Lorentz boost core testbench top: drives directed and random four-vector pairs
// with varied idling and stalls, and gives the verdict from the checker's count.
// Depends on lbfv_pkg, lbfv_chan_if, lorentz_boost_four_vector_core, lbfv_boost_checker.
`timescale 1ns / 100ps
module tb_lorentz_boost_four_vector_core;
	import lbfv_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int LATENCY = 145;

	logic clk;
	logic arst_n;
	int   send_idle;
	int   recv_idle;
	logic stall_on;
	int   mismatches;
	int   outstanding;
	int   cycles;
	int   sent;
	event long_stall;

	lbfv_chan_if #(.T(in_item_t))  feed ();
	lbfv_chan_if #(.T(out_item_t)) boost ();

	lorentz_boost_four_vector_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.feed   (feed),
		.boost  (boost)
	);

	lbfv_boost_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.feed_valid  (feed.valid),
		.feed_ready  (feed.ready),
		.feed_data   (feed.data),
		.boost_valid (boost.valid),
		.boost_ready (boost.ready),
		.boost_data  (boost.data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		feed.valid = 1'b0;
		feed.data = '0;
		boost.ready = 1'b0;
		stall_on = 1'b0;
		send_idle = 0;
		recv_idle = 0;
		cycles = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk)
		boost.ready <= !stall_on && ($urandom_range(99) >= recv_idle);

	// hold the output for a long stretch while the sender keeps offering items
	initial begin
		forever begin
			@(long_stall);
			stall_on <= 1'b1;
			repeat (600) @(posedge clk);
			stall_on <= 1'b0;
		end
	end

	task automatic send_item(input in_item_t x);
		while ($urandom_range(99) < send_idle) begin
			feed.valid <= 1'b0;
			@(posedge clk);
		end
		feed.valid <= 1'b1;
		feed.data <= x;
		do
			@(posedge clk);
		while (!feed.ready);
		sent++;
	endtask

	function automatic in_item_t make_pair(input logic signed [31:0] ppx,
		input logic signed [31:0] ppy, input logic signed [31:0] ppz, input logic [30:0] pe,
		input logic signed [31:0] qx, input logic signed [31:0] qy,
		input logic signed [31:0] qz, input logic [30:0] qe);
		in_item_t x;
		x.particle_px = ppx;
		x.particle_py = ppy;
		x.particle_pz = ppz;
		x.particle_energy = pe;
		x.parent_px = qx;
		x.parent_py = qy;
		x.parent_pz = qz;
		x.parent_energy = qe;
		return x;
	endfunction

	function automatic logic signed [31:0] signed_below(input int unsigned lim);
		logic signed [31:0] v;
		v = $urandom_range(lim);
		return $urandom_range(1) ? -v : v;
	endfunction

	function automatic in_item_t random_pair();
		in_item_t x;
		int unsigned ep;
		x = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom});
		if ($urandom_range(99) < 15)
			return x;
		ep = ($urandom >> $urandom_range(1, 31)) | 1;
		x.parent_energy = 31'(ep);
		if ($urandom_range(4) == 0) begin
			x.parent_px = signed_below(ep - 1);
			x.parent_py = signed_below((ep - 1) / 64);
			x.parent_pz = signed_below((ep - 1) / 64);
		end else begin
			x.parent_px = signed_below(ep / 2);
			x.parent_py = signed_below(ep / 2);
			x.parent_pz = signed_below(ep / 2);
		end
		x.particle_px = $signed(x.particle_px) >>> $urandom_range(31);
		x.particle_py = $signed(x.particle_py) >>> $urandom_range(31);
		x.particle_pz = $signed(x.particle_pz) >>> $urandom_range(31);
		x.particle_energy = x.particle_energy >> $urandom_range(30);
		return x;
	endfunction

	task automatic drain();
		feed.valid <= 1'b0;
		wait (outstanding == 0);
		repeat (LATENCY + 20) @(posedge clk);
	endtask

	initial begin
		sent = 0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(make_pair(32'sd100, -32'sd50, 32'sd7, 31'd200, 0, 0, 0, 31'd0));
		send_item(make_pair(-32'sd1, -32'sd1, -32'sd1, 31'h7FFF_FFFF,
			-32'sd1, -32'sd1, -32'sd1, 31'd0));
		send_item(make_pair(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, 31'h7FFF_FFFF,
			0, 0, 0, 31'd1));
		send_item(make_pair(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 31'd0,
			0, 0, 0, 31'h7FFF_FFFF));
		send_item(make_pair(32'sd64, 32'sd64, 32'sd64, 31'd200, 32'sd5, 0, 0, 31'd5));
		send_item(make_pair(32'sd64, 32'sd64, 32'sd64, 31'd200, 0, -32'sd6, 0, 31'd5));
		send_item(make_pair(32'sd64, 32'sd64, 32'sd64, 31'd200, 32'sd3, 32'sd3, 32'sd3,
			31'd5));
		send_item(make_pair(32'sd64, 0, 0, 31'd100, 32'sh8000_0000, 0, 0, 31'h7FFF_FFFF));
		send_item(make_pair(32'sd64, 32'sd10, -32'sd3, 31'd100, 32'sh7FFF_FFFE, 0, 0,
			31'h7FFF_FFFF));
		send_item(make_pair(0, 0, -32'sd1000, 31'd1000, 0, 0, 32'sh7FFF_FFFE,
			31'h7FFF_FFFF));
		send_item(make_pair(32'sh7FFF_FFFF, 0, 0, 31'h7FFF_FFFF, 32'sd900, 0, 0, 31'd1000));
		send_item(make_pair(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 31'h7FFF_FFFF,
			-32'sd500, -32'sd500, -32'sd500, 31'd1000));
		send_item(make_pair(-32'sd100000, 0, 0, 31'd1, 32'sd900, 0, 0, 31'd1000));
		send_item(make_pair(32'sd640, 32'sd320, 32'sd160, 31'd1000, 32'sd30, 32'sd40, 0,
			31'd100));
		send_item(make_pair(32'sd1, -32'sd1, 32'sd1, 31'd2, 0, 0, 0, 31'h7FFF_FFFF));
		send_item(make_pair(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF,
			32'sh4000_0000, 32'sh4000_0000, 32'sh4000_0000, 31'h7FFF_FFFF));
		send_item(make_pair(0, 0, 0, 31'd0, -32'sd1, 32'sd1, -32'sd1, 31'd2));
		send_item(make_pair(32'sd12345, -32'sd678, 32'sd9, 31'd20000, -32'sd7, 32'sd8,
			-32'sd9, 31'd20));
		drain();

		send_idle = 30;
		recv_idle = 71;
		repeat (600) send_item(random_pair());
		->long_stall;
		repeat (200) send_item(random_pair());
		drain();

		send_idle = 71;
		recv_idle = 30;
		repeat (600) send_item(random_pair());
		drain();

		send_idle = 0;
		recv_idle = 0;
		repeat (300) send_item(random_pair());
		->long_stall;
		repeat (300) send_item(random_pair());
		drain();

		$display("Boosted %0d four-vectors: parents at rest, invalid and extreme boosts,",
			sent);
		$display("saturating outputs, random sender and receiver idling and long stalls.");
		if (mismatches == 0 && outstanding == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
